// ===== rtl/chb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the chunked body decoder.
// No dependencies; the other files that use it refer to this package by scoped names.
package chb_pkg;

  // Width of the chunk size accumulator; the size may use up to this many bits.
  localparam int unsigned SizeBits = 32;
  // Width of the decoded body length counter.
  localparam int unsigned LenBits  = 32;

  localparam logic [7:0] LineFeed = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         out_byte;
    logic [LenBits-1:0] body_length;
  } result_t;

endpackage

// ===== rtl/chb_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the chunked body decoder: one body byte per beat.
// Depends on nothing but the valid/ready handshake convention.
interface chb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_start;

  modport source (output valid, output in_byte, output message_start, input ready);
  modport sink   (input valid, input in_byte, input message_start, output ready);
endinterface

// ===== rtl/chb_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the chunked body decoder: one result per beat.
// Depends on chb_pkg for the kind codes and the length width.
interface chb_out_if;
  logic                         valid;
  logic                         ready;
  chb_pkg::kind_e               kind;
  logic [7:0]                   out_byte;
  logic [chb_pkg::LenBits-1:0]  body_length;

  modport source (output valid, output kind, output out_byte, output body_length,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input body_length,
                  output ready);
endinterface

// ===== rtl/chb_parser.sv =====
`timescale 1ns / 1ps
// Parser state and the per-byte decode step of the chunked body decoder.
// Depends on chb_pkg; the result it forms is registered by the top level.
module chb_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       in_byte_i,
  input  logic             message_start_i,
  output logic             res_vld_o,
  output chb_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_TRAIL = 3'd2,
    PH_LAST  = 3'd3,
    PH_IDLE  = 3'd4
  } phase_e;

  localparam int unsigned SB = chb_pkg::SizeBits;
  localparam int unsigned LB = chb_pkg::LenBits;

  phase_e          phase_q, phase_d;
  logic            digits_done_q, digits_done_d;
  logic [SB-1:0]   rem_q, rem_d;
  logic [1:0]      skip_q, skip_d;
  logic [LB-1:0]   total_q, total_d;

  // Current state as seen by this byte: a message start restarts the parser.
  phase_e          ph_c;
  logic            digits_done_c;
  logic [SB-1:0]   rem_c;
  logic [1:0]      skip_c;
  logic [LB-1:0]   total_c;

  logic [SB-1:0]   rem_dec;
  logic [1:0]      skip_dec;
  logic [4:0]      hex;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  always_comb begin
    ph_c          = message_start_i ? PH_SIZE : phase_q;
    digits_done_c = message_start_i ? 1'b0 : digits_done_q;
    rem_c         = message_start_i ? '0 : rem_q;
    skip_c        = message_start_i ? 2'd0 : skip_q;
    total_c       = message_start_i ? '0 : total_q;

    rem_dec  = rem_c - SB'(1);
    skip_dec = skip_c - 2'd1;
    hex      = hex_decode(in_byte_i);

    phase_d       = ph_c;
    digits_done_d = digits_done_c;
    rem_d         = rem_c;
    skip_d        = skip_c;
    total_d       = total_c;
    res_vld_o     = 1'b0;
    res_o         = '{kind: chb_pkg::KIND_DATA, out_byte: 8'd0, body_length: '0};

    unique case (ph_c)
      PH_SIZE: begin
        if (in_byte_i == chb_pkg::LineFeed) begin
          digits_done_d = 1'b0;
          skip_d        = 2'd2;
          phase_d       = (rem_c == '0) ? PH_LAST : PH_DATA;
        end else if (!digits_done_c) begin
          if (!hex[4]) begin
            digits_done_d = 1'b1;
          end else if (rem_c[SB-1 -: 4] != 4'd0) begin
            // One more digit would push the size past its width.
            phase_d    = PH_IDLE;
            res_vld_o  = 1'b1;
            res_o.kind = chb_pkg::KIND_ERROR;
          end else begin
            rem_d = {rem_c[SB-5:0], hex[3:0]};
          end
        end
      end
      PH_DATA: begin
        rem_d = rem_dec;
        if (total_c != '1) begin
          total_d = total_c + LB'(1);
        end
        if (rem_dec == '0) begin
          phase_d = PH_TRAIL;
        end
        res_vld_o      = 1'b1;
        res_o.out_byte = in_byte_i;
      end
      PH_TRAIL: begin
        skip_d = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_d       = PH_SIZE;
          digits_done_d = 1'b0;
          rem_d         = '0;
        end
      end
      PH_LAST: begin
        skip_d = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_d           = PH_IDLE;
          res_vld_o         = 1'b1;
          res_o.kind        = chb_pkg::KIND_END;
          res_o.body_length = total_c;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SIZE;
      digits_done_q <= 1'b0;
      rem_q         <= '0;
      skip_q        <= 2'd0;
      total_q       <= '0;
    end else if (en_i) begin
      phase_q       <= phase_d;
      digits_done_q <= digits_done_d;
      rem_q         <= rem_d;
      skip_q        <= skip_d;
      total_q       <= total_d;
    end
  end

  // A data phase always has at least one byte left to pass.
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != '0)
    else $error("data phase with zero bytes remaining");

  // Trailer phases always have a byte left to skip.
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TRAIL || phase_q == PH_LAST) |-> skip_q != 2'd0)
    else $error("trailer phase with nothing to skip");

  // A finished body stays finished until a new message starts.
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE && !(en_i && message_start_i)) |=> phase_q == PH_IDLE)
    else $error("parser left idle without a message start");

endmodule

// ===== rtl/chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// A result is registered in out_q, or in skid_q while out_q is stalled, as its input beat is accepted.
// Throughput: one input byte per cycle, sustained while the output side keeps up.
// A two-entry result buffer keeps input flowing while the output stalls, until the spare slot fills.
// Reset (rst_ni, asynchronous, active low) returns the parser to the start of a
// body and empties the result buffer; no clearing pass is needed.
// Depends on chb_pkg, chb_in_if, chb_out_if and chb_parser.
module chunked_body_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  chb_in_if.sink        in_i,
  chb_out_if.source     out_o
);

  // An input beat is taken whenever the spare result slot is free. The parser
  // decides in the same cycle whether this byte produces a result, and its
  // state registers are updated on that same edge, so the next byte can
  // follow immediately.
  logic             accept;
  logic             res_vld;
  chb_pkg::result_t res;

  // The result buffer: out_q drives the port, skid_q catches a result that
  // arrives while out_q is stalled.
  logic             out_vld_q;
  chb_pkg::result_t out_q;
  logic             skid_vld_q;
  chb_pkg::result_t skid_q;

  logic             push;
  logic             pop;

  assign in_i.ready = !skid_vld_q;
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && res_vld;
  assign pop        = out_vld_q && out_o.ready;

  chb_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (accept),
    .in_byte_i       (in_i.in_byte),
    .message_start_i (in_i.message_start),
    .res_vld_o       (res_vld),
    .res_o           (res)
  );

  // Valid flags of the buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        // No push can happen here, since the input is held off.
        if (pop) begin
          skid_vld_q <= 1'b0;
        end
      end else if (!out_vld_q || pop) begin
        out_vld_q <= push;
      end else if (push) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // Payload of the buffer; no reset needed.
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || pop) begin
      if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.body_length = out_q.body_length;

  // The spare slot is only ever filled behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("spare result slot full while output is empty");

  // A result held in the spare slot moves to the output once it is taken.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && out_o.ready) |=> (out_vld_q && !skid_vld_q))
    else $error("spare result slot did not drain");

  // A result waiting on the output holds still until it is taken.
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> (out_vld_q && $stable(out_q)))
    else $error("waiting result beat changed before it was taken");

endmodule

// ===== bench/chunked_body_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for chunked_body_decoder: directed table, then random chunked bodies.
// Depends on chb_pkg, chb_in_if, chb_out_if and the decoder RTL.
module chunked_body_decoder_tb;

  // Byte values that shape a chunk size line.
  localparam logic [7:0] CarriageReturn = 8'h0D;
  localparam logic [7:0] Semicolon      = 8'h3B;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned BeatsPerPhase = 425;

  // Parser states of the decode model kept by the testbench.
  typedef enum logic [2:0] {
    ST_SIZE  = 3'd0,
    ST_DATA  = 3'd1,
    ST_TRAIL = 3'd2,
    ST_LAST  = 3'd3,
    ST_IDLE  = 3'd4
  } parse_st_e;

  // One row of the directed table. When known is set, the row carries the result
  // that the beat must produce; otherwise the decode model decides.
  typedef struct {
    logic [7:0]       in_byte;
    logic             start;
    bit               known;
    chb_pkg::result_t res;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  chb_in_if  in_bus ();
  chb_out_if out_bus ();

  chunked_body_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decode model state.
  parse_st_e                    ps_state;
  logic                         digits_done;
  logic [chb_pkg::SizeBits-1:0] chunk_left;
  logic [1:0]                   skip_cnt;
  logic [chb_pkg::LenBits-1:0]  body_count;
  logic                         body_done;

  // Results the decoder still owes us, oldest first.
  chb_pkg::result_t pending_results [$];
  int unsigned errors;
  int unsigned beats;
  int unsigned n_data, n_end, n_overflow;
  int unsigned send_idle_pct, recv_stall_pct;
  logic        open_start;

  int unsigned idle_send  [NumPhases] = '{0, 57, 0, 28};
  int unsigned stall_recv [NumPhases] = '{0, 0, 57, 28};

  // Directed table. It starts right after reset without a message_start, covers
  // both data byte extremes, a line without digits, trailer bytes that look like
  // a line feed or a digit, a "0x" prefix, and a size that runs past 32 bits
  // followed by a byte that must be ignored.
  stim_row_t dir_rows [25] = '{
    '{8'h32, 1'b0, 1'b0, '0},                            // "2"
    '{8'h0A, 1'b0, 1'b0, '0},                            // line feed
    '{8'h00, 1'b0, 1'b1, '{chb_pkg::KIND_DATA, 8'h00, 32'd0}},
    '{8'hFF, 1'b0, 1'b1, '{chb_pkg::KIND_DATA, 8'hFF, 32'd0}},
    '{8'hFF, 1'b0, 1'b0, '0},                            // trailer, any value
    '{8'h0A, 1'b0, 1'b0, '0},                            // trailer, a line feed
    '{8'h0A, 1'b0, 1'b0, '0},                            // empty size line
    '{8'h35, 1'b0, 1'b0, '0},                            // final trailer
    '{8'h41, 1'b0, 1'b1, '{chb_pkg::KIND_END, 8'h00, 32'd2}},
    '{8'h30, 1'b1, 1'b0, '0},                            // new body: "0x1"
    '{8'h78, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{chb_pkg::KIND_END, 8'h00, 32'd0}},
    '{8'h66, 1'b1, 1'b0, '0},                            // new body: "fFaBcDe91"
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, '0},
    '{8'h63, 1'b0, 1'b0, '0},
    '{8'h44, 1'b0, 1'b0, '0},
    '{8'h65, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b1, '{chb_pkg::KIND_ERROR, 8'h00, 32'd0}},
    '{8'h0A, 1'b0, 1'b0, '0}                             // ignored after the error
  };

  function automatic void clear_parser();
    ps_state    = ST_SIZE;
    digits_done = 1'b0;
    chunk_left  = '0;
    skip_cnt    = '0;
    body_count  = '0;
    body_done   = 1'b0;
  endfunction

  // Returns 1 and the digit value when the byte is a hex digit of either case.
  function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] nib);
    nib = '0;
    if (b >= 8'h30 && b <= 8'h39) nib = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) nib = 4'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) nib = 4'(b - 8'h41 + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Advances the decode model by one accepted beat. Returns 1 when the beat
  // produces a result, which is then left in res.
  function automatic bit decode_step(input logic [7:0] b, input logic start,
                                     output chb_pkg::result_t res);
    logic [3:0] nib;
    res = '0;
    if (start) clear_parser();
    if (body_done || ps_state == ST_IDLE) return 1'b0;
    case (ps_state)
      ST_SIZE: begin
        if (b == chb_pkg::LineFeed) begin
          digits_done = 1'b0;
          skip_cnt    = 2'd2;
          ps_state    = (chunk_left == '0) ? ST_LAST : ST_DATA;
          return 1'b0;
        end
        if (digits_done) return 1'b0;
        if (!hex_digit(b, nib)) begin
          digits_done = 1'b1;
          return 1'b0;
        end
        // One more digit would shift set bits out of the size field.
        if (chunk_left[chb_pkg::SizeBits-1 -: 4] != 4'd0) begin
          body_done = 1'b1;
          ps_state  = ST_IDLE;
          res.kind  = chb_pkg::KIND_ERROR;
          return 1'b1;
        end
        chunk_left = {chunk_left[chb_pkg::SizeBits-5:0], nib};
        return 1'b0;
      end
      ST_DATA: begin
        chunk_left = chunk_left - 1'b1;
        if (body_count != '1) body_count = body_count + 1'b1;
        if (chunk_left == '0) ps_state = ST_TRAIL;
        res.kind     = chb_pkg::KIND_DATA;
        res.out_byte = b;
        return 1'b1;
      end
      ST_TRAIL: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == 2'd0) begin
          ps_state    = ST_SIZE;
          digits_done = 1'b0;
          chunk_left  = '0;
        end
        return 1'b0;
      end
      ST_LAST: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == 2'd0) begin
          body_done       = 1'b1;
          ps_state        = ST_IDLE;
          res.kind        = chb_pkg::KIND_END;
          res.body_length = body_count;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one beat, with random idle cycles in front of it, and waits until the
  // decoder takes it. valid stays high after the beat so that back-to-back beats
  // never see valid drop and rise within one time step.
  task automatic send_beat(input logic [7:0] b, input logic start,
                           input bit known, input chb_pkg::result_t known_res);
    chb_pkg::result_t pred;
    bit               has_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.in_byte       <= b;
    in_bus.message_start <= start;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    has_res = decode_step(b, start, pred);
    if (known) pending_results.push_back(known_res);
    else if (has_res) pending_results.push_back(pred);
    beats++;
  endtask

  // Sends a body byte; the first byte of a body carries message_start if one is due.
  task automatic put_byte(input logic [7:0] b);
    send_beat(b, open_start, 1'b0, '0);
    open_start = 1'b0;
  endtask

  task automatic send_size_line(input logic [31:0] size, input bit no_digits);
    int unsigned ndig;
    logic [7:0]  junk;
    if (!no_digits) begin
      ndig = 1;
      while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
      // A few lines carry leading zeros, which must not change the size.
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 2)) put_byte(hex_char(4'd0, 1'b0));
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        put_byte(hex_char(size[4*i +: 4], 1'($urandom_range(0, 1))));
      end
    end
    // A chunk extension: anything up to the line feed is skipped, digits too.
    if ($urandom_range(0, 4) == 0) begin
      put_byte(Semicolon);
      repeat ($urandom_range(0, 3)) begin
        junk = 8'($urandom_range(0, 255));
        if (junk == chb_pkg::LineFeed) junk = Semicolon;
        put_byte(junk);
      end
    end
    if ($urandom_range(0, 9) != 0) put_byte(CarriageReturn);
    put_byte(chb_pkg::LineFeed);
  endtask

  task automatic send_trailer();
    if ($urandom_range(0, 6) != 0) begin
      put_byte(CarriageReturn);
      put_byte(chb_pkg::LineFeed);
    end else begin
      repeat (2) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // One random body. Most are well formed with random sizes and contents; the
  // rest end in a size overflow, are cut short by the next message_start, or
  // are plain noise.
  task automatic send_body();
    int unsigned roll, size;
    open_start = ($urandom_range(0, 9) != 0);
    roll       = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      size = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      send_size_line(size, 1'b0);
      repeat (size) put_byte(8'($urandom_range(0, 255)));
      send_trailer();
    end
    if (roll < 18) begin
      // A leading nonzero digit guarantees that the ninth digit overflows.
      put_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
      repeat ($urandom_range(8, 11)) begin
        put_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      put_byte(CarriageReturn);
      put_byte(chb_pkg::LineFeed);
    end else if (roll < 28) begin
      size = $urandom_range(0, 1) ? $urandom : $urandom_range(2, 40);
      if (size == 0) size = 1;
      send_size_line(size, 1'b0);
      repeat ($urandom_range(0, (size < 40) ? size - 1 : 39)) begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      send_size_line(32'd0, $urandom_range(0, 9) == 0);
      send_trailer();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Output side: checks every result beat against the oldest expectation and
  // drives ready with random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    chb_pkg::result_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: kind %0d, out_byte %0h, body_length %0d",
                 out_bus.kind, out_bus.out_byte, out_bus.body_length);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_bus.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
            errors++;
          end
          if (out_bus.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_bus.out_byte);
            errors++;
          end
          if (out_bus.body_length !== want.body_length) begin
            $error("body_length: expected %0d, got %0d", want.body_length,
                   out_bus.body_length);
            errors++;
          end
          case (want.kind)
            chb_pkg::KIND_DATA: n_data++;
            chb_pkg::KIND_END:  n_end++;
            default:            n_overflow++;
          endcase
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned target;
    in_bus.valid         = 1'b0;
    in_bus.in_byte       = 8'h00;
    in_bus.message_start = 1'b0;
    errors         = 0;
    beats          = 0;
    n_data         = 0;
    n_end          = 0;
    n_overflow     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    open_start     = 1'b0;
    clear_parser();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, with no idling on either side.
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].in_byte, dir_rows[i].start, dir_rows[i].known, dir_rows[i].res);
    end

    // Random bodies under each idling pattern. The sender goes quiet at every
    // phase boundary until all results are in.
    for (int p = 0; p < NumPhases; p++) begin
      in_bus.valid <= 1'b0;
      wait_drained();
      send_idle_pct  = idle_send[p];
      recv_stall_pct = stall_recv[p];
      target         = beats + BeatsPerPhase;
      while (beats < target) send_body();
    end

    in_bus.valid <= 1'b0;
    recv_stall_pct = 0;
    wait_drained();
    // A stray result beat would show up within a few cycles.
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("Sent %0d input beats; checked %0d data bytes, %0d body ends",
             beats, n_data, n_end);
    $display("and %0d size overflows.", n_overflow);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // The whole run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
